@@ rtl/source_text_tokenizer_top_assert.svh @@
// Assertion helpers for the tokenizer
`ifndef SOURCE_TEXT_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_ASSERT_SVH
// assert that an antecedent implies a consequent in the same cycle
`define STT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// assert that an antecedent implies a consequent in the next cycle
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/stt_pkg.sv @@
`timescale 1ns / 1ps
package stt_pkg;
   localparam logic [5:0] K_IDENT = 6'd18, K_INTC = 6'd19, K_FLOATC = 6'd20, K_STRC = 6'd21,
      K_LPAR = 6'd22, K_RPAR = 6'd23, K_LCURLY = 6'd24, K_RCURLY = 6'd25, K_EQUAL = 6'd26,
      K_EQEQ = 6'd27, K_EXCL = 6'd28, K_NOTEQ = 6'd29, K_PLUS = 6'd30, K_PLUSEQ = 6'd31,
      K_MINUS = 6'd32, K_MINUSEQ = 6'd33, K_ARROW = 6'd34, K_STAR = 6'd35, K_STAREQ = 6'd36,
      K_SLASH = 6'd37, K_SLASHEQ = 6'd38, K_BAR = 6'd39, K_AMP = 6'd40, K_POUND = 6'd41,
      K_SEMI = 6'd42, K_LT = 6'd43, K_LTE = 6'd44, K_SHL = 6'd45, K_GT = 6'd46,
      K_GTE = 6'd47, K_SHR = 6'd48, K_LBRACK = 6'd49, K_RBRACK = 6'd50, K_COLON = 6'd51,
      K_COLONEQ = 6'd52, K_PERCENT = 6'd53, K_CARET = 6'd54, K_TILDE = 6'd55,
      K_COMMA = 6'd56, K_PERIOD = 6'd57, K_ELLIPSIS = 6'd58, K_NONE = 6'd59, K_END = 6'd60;

   localparam logic [2:0] E_NONE = 3'd0, E_DOTDOT = 3'd1, E_UNKNOWN = 3'd2,
      E_UNTERM = 3'd3, E_DEEP = 3'd4;

   localparam logic [3:0] M_IDLE = 4'd0, M_OP = 4'd1, M_LINECMT = 4'd2, M_BLOCK = 4'd3,
      M_INT = 4'd4, M_NUMDOT = 4'd5, M_FRAC = 4'd6, M_IDENT = 4'd7, M_STRING = 4'd8,
      M_DOT1 = 4'd9, M_DOT2 = 4'd10;

   localparam int NUM_KEYWORDS = 18;
   localparam int KW_SLOTS = 7;
   localparam logic [7:0] RESET_MAX_DEPTH = 8'd32;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [2:0]  error_code;
      logic [19:0] line_number;
      logic [23:0] token_start;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_type;

   // one emitted token before line stamping
   typedef struct packed {
      logic        valid;
      logic [5:0]  kind;
      logic [2:0]  err;
      logic [23:0] start;
      logic [15:0] len;
   } tok_type;

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         "=": k = K_EQUAL;
         "!": k = K_EXCL;
         "+": k = K_PLUS;
         "-": k = K_MINUS;
         "*": k = K_STAR;
         "/": k = K_SLASH;
         "<": k = K_LT;
         ">": k = K_GT;
         ":": k = K_COLON;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
      logic [5:0] k;
      k = K_NONE;
      if (b == "=") begin
         case (a)
            "=": k = K_EQEQ;
            "!": k = K_NOTEQ;
            "+": k = K_PLUSEQ;
            "-": k = K_MINUSEQ;
            "*": k = K_STAREQ;
            "/": k = K_SLASHEQ;
            "<": k = K_LTE;
            ">": k = K_GTE;
            ":": k = K_COLONEQ;
            default: k = K_NONE;
         endcase
      end else if (a == "-" && b == ">") begin
         k = K_ARROW;
      end else if (a == "<" && b == "<") begin
         k = K_SHL;
      end else if (a == ">" && b == ">") begin
         k = K_SHR;
      end
      return k;
   endfunction

   function automatic logic [5:0] immediate_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         "(": k = K_LPAR;
         ")": k = K_RPAR;
         "{": k = K_LCURLY;
         "}": k = K_RCURLY;
         "|": k = K_BAR;
         "&": k = K_AMP;
         "#": k = K_POUND;
         ";": k = K_SEMI;
         "[": k = K_LBRACK;
         "]": k = K_RBRACK;
         "%": k = K_PERCENT;
         "^": k = K_CARET;
         "~": k = K_TILDE;
         ",": k = K_COMMA;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_let(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   // keyword lookup over the first seven captured characters and the length
   function automatic logic [5:0] keyword_kind(input logic [KW_SLOTS*8-1:0] t,
                                                input logic [15:0] n);
      logic [5:0] k;
      k = K_IDENT;
      case (n)
         16'd2: begin
            if (t[15:0] == {"f", "i"}) k = 6'd0;
            else if (t[15:0] == {"r", "o"}) k = 6'd15;
         end
         16'd3: begin
            if (t[23:0] == {"t", "n", "i"}) k = 6'd1;
            else if (t[23:0] == {"r", "o", "f"}) k = 6'd8;
            else if (t[23:0] == {"d", "n", "a"}) k = 6'd14;
         end
         16'd4: begin
            if (t[31:0] == {"e", "s", "l", "e"}) k = 6'd2;
            else if (t[31:0] == {"f", "i", "l", "e"}) k = 6'd3;
            else if (t[31:0] == {"r", "a", "h", "c"}) k = 6'd12;
            else if (t[31:0] == {"t", "s", "a", "c"}) k = 6'd13;
            else if (t[31:0] == {"e", "u", "r", "t"}) k = 6'd16;
         end
         16'd5: begin
            if (t[39:0] == {"k", "a", "e", "r", "b"}) k = 6'd6;
            else if (t[39:0] == {"t", "a", "o", "l", "f"}) k = 6'd7;
            else if (t[39:0] == {"e", "s", "l", "a", "f"}) k = 6'd9;
            else if (t[39:0] == {"e", "l", "i", "h", "w"}) k = 6'd10;
            else if (t[39:0] == {"t", "n", "i", "r", "p"}) k = 6'd17;
         end
         16'd6: begin
            if (t[47:0] == {"g", "n", "i", "r", "t", "s"}) k = 6'd4;
            else if (t[47:0] == {"n", "r", "u", "t", "e", "r"}) k = 6'd11;
         end
         16'd7: begin
            if (t[55:0] == {"n", "a", "e", "l", "o", "o", "b"}) k = 6'd5;
         end
         default: k = K_IDENT;
      endcase
      return k;
   endfunction
endpackage

@@ rtl/stt_outq.sv @@
`timescale 1ns / 1ps
// Result queue: takes up to three words per cycle while it has room, delivers one per cycle while rsp_ready is high.
module stt_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_count,
   input  stt_pkg::rsp_type  push_word [3],
   output logic              can_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stt_pkg::rsp_type  rsp_data
);
   localparam int DEPTH = 4;
   stt_pkg::rsp_type mem_ff [DEPTH];
   logic [1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic pop;

   assign pop = rsp_valid && rsp_ready;
   assign rsp_valid = cnt_ff != 3'd0;
   assign rsp_data = mem_ff[rd_ff];
   // room for a worst-case three-word burst after this cycle's pop
   assign can_take = (cnt_ff <= 3'd1) || (cnt_ff == 3'd2 && pop) ;

   always_comb begin
      rd_in = rd_ff + {1'b0, pop};
      wr_in = wr_ff + push_count;
      cnt_in = cnt_ff + {1'b0, push_count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push_count) mem_ff[wr_ff + 2'(i)] <= push_word[i];
      end
   end
endmodule

@@ rtl/source_text_tokenizer_top.sv @@
`timescale 1ns / 1ps
// Byte-serial lexer. A token is pushed into the result queue when the word that completes it
// is accepted; most tokens complete on the following byte (one byte lookahead).
// Throughput: one input word per cycle while the result queue has room; a byte can yield
// up to three result words; the four-entry queue drains one per cycle while rsp_ready is high.
// Reset: synchronous, active high; clears scanner state, offset 0, line 1, depth limit 32.
module source_text_tokenizer_top #(
   parameter int POSITION_WIDTH  = 24,
   parameter int LINE_WIDTH      = 20,
   parameter int KEYWORD_MAX_LEN = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stt_pkg::rsp_type  rsp_data,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data
);
   `include "source_text_tokenizer_top_assert.svh"

   localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;
   localparam int KW_BITS = KEYWORD_MAX_LEN * 8;

   // scanner state
   logic [3:0]                mode_ff, mode_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [LINE_WIDTH-1:0]     line_ff, line_in;
   logic [POSITION_WIDTH-1:0] lex_ff, lex_in;
   logic [7:0]                depth_ff, depth_in;
   logic [7:0]                held_ff, held_in;
   logic [15:0]               run_ff, run_in;
   logic [KW_BITS-1:0]        kw_ff, kw_in;
   logic [7:0]                max_depth_ff;

   logic accept, can_take;
   logic [7:0] b;
   logic fin;
   logic [POSITION_WIDTH-1:0] prev;
   stt_pkg::tok_type tok [3];
   logic [1:0] ntok;
   stt_pkg::rsp_type word [3];
   logic [15:0] run_p1, run_p2;
   logic [5:0]  idk;

   assign req_ready = can_take;
   assign accept = req_valid && req_ready;
   assign b = req_data.text_byte;
   assign fin = req_data.end_of_input || b == 8'd0;
   assign prev = pos_ff - 1'b1;
   assign run_p1 = (run_ff == 16'hFFFF) ? run_ff : run_ff + 16'd1;
   assign run_p2 = (run_ff >= 16'hFFFE) ? 16'hFFFF : run_ff + 16'd2;
   assign idk = stt_pkg::keyword_kind(kw_ff[stt_pkg::KW_SLOTS*8-1:0], run_ff);

   function automatic stt_pkg::tok_type mk(input logic [5:0] k, input logic [2:0] e,
                                           input logic [POSITION_WIDTH-1:0] s,
                                           input logic [15:0] n);
      stt_pkg::tok_type t;
      t.valid = 1'b1;
      t.kind = k;
      t.err = e;
      t.start = 24'(s);
      t.len = n;
      return t;
   endfunction

   // scanner next state and up to three tokens for the byte on the input
   always_comb begin
      logic reprocess;
      logic [5:0] k;
      mode_in = mode_ff;
      pos_in = pos_ff;
      line_in = line_ff;
      lex_in = lex_ff;
      depth_in = depth_ff;
      held_in = held_ff;
      run_in = run_ff;
      kw_in = kw_ff;
      for (int i = 0; i < 3; i++) tok[i] = '0;
      reprocess = 1'b0;
      k = stt_pkg::K_NONE;
      if (fin) begin
         // flush any pending lexeme, then the end word; restart
         case (mode_ff)
            stt_pkg::M_OP: tok[0] = mk(stt_pkg::single_kind(held_ff), stt_pkg::E_NONE,
                                         lex_ff, 16'd1);
            stt_pkg::M_INT: tok[0] = mk(stt_pkg::K_INTC, stt_pkg::E_NONE, lex_ff, run_ff);
            stt_pkg::M_NUMDOT: begin
               tok[0] = mk(stt_pkg::K_INTC, stt_pkg::E_NONE, lex_ff, run_ff);
               tok[1] = mk(stt_pkg::K_PERIOD, stt_pkg::E_NONE, prev, 16'd1);
            end
            stt_pkg::M_FRAC: tok[0] = mk(stt_pkg::K_FLOATC, stt_pkg::E_NONE, lex_ff, run_ff);
            stt_pkg::M_IDENT: tok[0] = mk(idk, stt_pkg::E_NONE, lex_ff, run_ff);
            stt_pkg::M_STRING: tok[0] = mk(stt_pkg::K_STRC, stt_pkg::E_UNTERM,
                                             lex_ff + 1'b1, run_ff);
            stt_pkg::M_DOT1: tok[0] = mk(stt_pkg::K_PERIOD, stt_pkg::E_NONE, lex_ff, 16'd1);
            stt_pkg::M_DOT2: tok[0] = mk(stt_pkg::K_NONE, stt_pkg::E_DOTDOT, lex_ff, 16'd2);
            default: ;
         endcase
         tok[2] = mk(stt_pkg::K_END, stt_pkg::E_NONE, pos_ff, 16'd0);
         mode_in = stt_pkg::M_IDLE;
         pos_in = '0;
         line_in = LINE_WIDTH'(1);
         lex_in = '0;
         depth_in = '0;
         held_in = '0;
         run_in = '0;
      end else begin
         pos_in = pos_ff + 1'b1;
         // first pass: the pending lexeme sees the byte
         case (mode_ff)
            stt_pkg::M_OP: begin
               k = stt_pkg::pair_kind(held_ff, b);
               if (held_ff == "/" && b == "/") begin
                  mode_in = stt_pkg::M_LINECMT;
               end else if (held_ff == "<" && b == "/") begin
                  if (max_depth_ff == 8'd0) begin
                     tok[0] = mk(stt_pkg::K_NONE, stt_pkg::E_DEEP, lex_ff, 16'd2);
                     mode_in = stt_pkg::M_IDLE;
                  end else begin
                     mode_in = stt_pkg::M_BLOCK;
                     depth_in = 8'd1;
                     held_in = '0;
                  end
               end else if (k != stt_pkg::K_NONE) begin
                  tok[0] = mk(k, stt_pkg::E_NONE, lex_ff, 16'd2);
                  mode_in = stt_pkg::M_IDLE;
               end else begin
                  tok[0] = mk(stt_pkg::single_kind(held_ff), stt_pkg::E_NONE, lex_ff, 16'd1);
                  reprocess = 1'b1;
               end
            end
            stt_pkg::M_LINECMT: begin
               if (b == "\n") reprocess = 1'b1;
            end
            stt_pkg::M_BLOCK: begin
               held_in = b;
               if (held_ff == "/" && b == ">") begin
                  depth_in = depth_ff - 8'd1;
                  if (depth_ff == 8'd1) begin
                     mode_in = stt_pkg::M_IDLE;
                     held_in = '0;
                  end else if (b == "\n" && line_ff != LINE_MAX) begin
                     line_in = line_ff + 1'b1;
                  end
               end else if (held_ff == "<" && b == "/" && depth_ff >= max_depth_ff) begin
                  tok[0] = mk(stt_pkg::K_NONE, stt_pkg::E_DEEP, prev, 16'd2);
                  depth_in = '0;
                  held_in = '0;
                  mode_in = stt_pkg::M_IDLE;
               end else begin
                  if (held_ff == "<" && b == "/") depth_in = depth_ff + 8'd1;
                  if (b == "\n" && line_ff != LINE_MAX) line_in = line_ff + 1'b1;
               end
            end
            stt_pkg::M_INT: begin
               if (stt_pkg::is_dig(b)) run_in = run_p1;
               else if (b == ".") mode_in = stt_pkg::M_NUMDOT;
               else begin
                  tok[0] = mk(stt_pkg::K_INTC, stt_pkg::E_NONE, lex_ff, run_ff);
                  reprocess = 1'b1;
               end
            end
            stt_pkg::M_NUMDOT: begin
               if (stt_pkg::is_dig(b)) begin
                  mode_in = stt_pkg::M_FRAC;
                  run_in = run_p2;
               end else begin
                  // int, then the dot acts as DOT1 on this byte
                  tok[0] = mk(stt_pkg::K_INTC, stt_pkg::E_NONE, lex_ff, run_ff);
                  lex_in = prev;
                  if (b == ".") mode_in = stt_pkg::M_DOT2;
                  else begin
                     tok[1] = mk(stt_pkg::K_PERIOD, stt_pkg::E_NONE, prev, 16'd1);
                     reprocess = 1'b1;
                  end
               end
            end
            stt_pkg::M_FRAC: begin
               if (stt_pkg::is_dig(b)) run_in = run_p1;
               else begin
                  tok[0] = mk(stt_pkg::K_FLOATC, stt_pkg::E_NONE, lex_ff, run_ff);
                  reprocess = 1'b1;
               end
            end
            stt_pkg::M_IDENT: begin
               if (stt_pkg::is_let(b) || stt_pkg::is_dig(b)) begin
                  for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                     if (run_ff == 16'(i)) kw_in[i*8 +: 8] = b;
                  run_in = run_p1;
               end else begin
                  tok[0] = mk(idk, stt_pkg::E_NONE, lex_ff, run_ff);
                  reprocess = 1'b1;
               end
            end
            stt_pkg::M_STRING: begin
               if (b == "\"") begin
                  tok[0] = mk(stt_pkg::K_STRC, stt_pkg::E_NONE, lex_ff + 1'b1, run_ff);
                  mode_in = stt_pkg::M_IDLE;
               end else begin
                  if (b == "\n" && line_ff != LINE_MAX) line_in = line_ff + 1'b1;
                  run_in = run_p1;
               end
            end
            stt_pkg::M_DOT1: begin
               if (b == ".") mode_in = stt_pkg::M_DOT2;
               else begin
                  tok[0] = mk(stt_pkg::K_PERIOD, stt_pkg::E_NONE, lex_ff, 16'd1);
                  reprocess = 1'b1;
               end
            end
            stt_pkg::M_DOT2: begin
               mode_in = stt_pkg::M_IDLE;
               if (b == ".") tok[0] = mk(stt_pkg::K_ELLIPSIS, stt_pkg::E_NONE, lex_ff, 16'd3);
               else begin
                  tok[0] = mk(stt_pkg::K_NONE, stt_pkg::E_DOTDOT, lex_ff, 16'd2);
                  reprocess = 1'b1;
               end
            end
            default: reprocess = 1'b1;
         endcase
         // second pass: the byte starts a new lexeme from idle
         if (reprocess) begin
            mode_in = stt_pkg::M_IDLE;
            lex_in = pos_ff;
            if (b == " " || b == "\t" || b == "\r") begin
               mode_in = stt_pkg::M_IDLE;
            end else if (b == "\n") begin
               if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
            end else if (stt_pkg::is_dig(b)) begin
               mode_in = stt_pkg::M_INT;
               run_in = 16'd1;
            end else if (stt_pkg::is_let(b)) begin
               mode_in = stt_pkg::M_IDENT;
               run_in = 16'd1;
               kw_in[7:0] = b;
            end else if (b == "\"") begin
               mode_in = stt_pkg::M_STRING;
               run_in = 16'd0;
            end else if (b == ".") begin
               mode_in = stt_pkg::M_DOT1;
            end else if (stt_pkg::single_kind(b) != stt_pkg::K_NONE) begin
               mode_in = stt_pkg::M_OP;
               held_in = b;
            end else begin
               k = stt_pkg::immediate_kind(b);
               tok[2] = mk(k, (k == stt_pkg::K_NONE) ? stt_pkg::E_UNKNOWN : stt_pkg::E_NONE,
                           pos_ff, 16'd1);
            end
         end
      end
   end

   // pack valid tokens in order; every token completes before any line bump of this
   // byte, so stamp the line held before it
   always_comb begin
      logic [1:0] n;
      logic [LINE_WIDTH-1:0] ln;
      n = 2'd0;
      ln = line_ff;
      for (int i = 0; i < 3; i++) word[i] = '0;
      for (int i = 0; i < 3; i++) begin
         if (tok[i].valid) begin
            word[n].token_kind = tok[i].kind;
            word[n].error_code = tok[i].err;
            word[n].line_number = 20'(ln);
            word[n].token_start = tok[i].start;
            word[n].token_length = tok[i].len;
            word[n].last_of_run = 1'b0;
            n = n + 2'd1;
         end
      end
      if (n != 2'd0) word[n - 2'd1].last_of_run = 1'b1;
      ntok = accept ? n : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stt_pkg::M_IDLE;
         pos_ff <= '0;
         line_ff <= LINE_WIDTH'(1);
         lex_ff <= '0;
         depth_ff <= '0;
         held_ff <= '0;
         run_ff <= '0;
         max_depth_ff <= stt_pkg::RESET_MAX_DEPTH;
      end else begin
         if (csr_write_enable) max_depth_ff <= csr_write_data;
         if (accept) begin
            mode_ff <= mode_in;
            pos_ff <= pos_in;
            line_ff <= line_in;
            lex_ff <= lex_in;
            depth_ff <= depth_in;
            held_ff <= held_in;
            run_ff <= run_in;
         end
      end
   end

   // captured identifier characters: no reset, read only after written
   always_ff @(posedge clock) begin
      if (accept) kw_ff <= kw_in;
   end

   stt_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_count (ntok),
      .push_word  (word),
      .can_take   (can_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   `STT_ASSERT_NEXT(a_end_restart, clock, reset, accept && fin, pos_ff == '0 && line_ff == LINE_WIDTH'(1), "end of input must restart offset and line")
   `STT_ASSERT_NOW(a_no_accept_full, clock, reset, !can_take, !accept, "word accepted with no queue room")
   `STT_ASSERT_NEXT(a_end_emits, clock, reset, accept && fin, rsp_valid, "end of input produced no result")
   `STT_ASSERT_NOW(a_depth_bound, clock, reset, mode_ff == stt_pkg::M_BLOCK, depth_ff != 8'd0, "block comment with zero depth")
endmodule
